@@ rtl/usbep_pkg.sv @@
// usbep_pkg: shared types, register field masks and update functions
// for the usb endpoint register bank; no dependencies
package usbep_pkg;

    // bank size, legal range 1 to 8
    localparam int NUM_ENDPOINTS = 8;

    localparam int REG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int CMP_W   = 5;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RX_DONE = 2'd2,
        OP_TX_DONE = 2'd3
    } op_t;

    // register layout masks
    localparam logic [REG_W-1:0] CTR_MASK     = 16'h8080;
    localparam logic [REG_W-1:0] RW_MASK      = 16'h070F;
    localparam logic [REG_W-1:0] TOGGLE_MASK  = 16'h7070;
    localparam logic [REG_W-1:0] SETUP_BIT    = 16'h0800;
    localparam logic [REG_W-1:0] CTR_RX_BIT   = 16'h8000;
    localparam logic [REG_W-1:0] CTR_TX_BIT   = 16'h0080;
    localparam logic [REG_W-1:0] DTOG_RX_BIT  = 16'h4000;
    localparam logic [REG_W-1:0] DTOG_TX_BIT  = 16'h0040;
    localparam logic [REG_W-1:0] STAT_RX_MASK = 16'h3000;
    localparam logic [REG_W-1:0] STAT_TX_MASK = 16'h0030;
    localparam logic [REG_W-1:0] STAT_RX_NAK  = 16'h2000;
    localparam logic [REG_W-1:0] STAT_TX_NAK  = 16'h0020;

    typedef struct packed {
        op_t              opcode;
        logic [IDX_W-1:0] ep_num;
        logic [REG_W-1:0] write_data;
        logic             setup_flag;
    } item_t;

    typedef struct packed {
        logic             ctr_pending;
        logic [IDX_W-1:0] pending_endpoint;
        logic             pending_dir;
    } pend_t;

    // complete flags clear on written 0, toggles flip on written 1,
    // plain fields load, setup kept
    function automatic logic [REG_W-1:0] bus_write(
        input logic [REG_W-1:0] cur,
        input logic [REG_W-1:0] w
    );
        logic [REG_W-1:0] r;
        r = cur & ((w & CTR_MASK) | ~CTR_MASK);
        r = (r & ~RW_MASK) | (w & RW_MASK);
        r = r ^ (w & TOGGLE_MASK);
        return r;
    endfunction

    function automatic logic [REG_W-1:0] rx_done(
        input logic [REG_W-1:0] cur,
        input logic             setup
    );
        logic [REG_W-1:0] r;
        r = (cur & ~(STAT_RX_MASK | SETUP_BIT)) | STAT_RX_NAK | CTR_RX_BIT;
        r = r ^ DTOG_RX_BIT;
        r = r | (setup ? SETUP_BIT : '0);
        return r;
    endfunction

    function automatic logic [REG_W-1:0] tx_done(
        input logic [REG_W-1:0] cur
    );
        logic [REG_W-1:0] r;
        r = (cur & ~STAT_TX_MASK) | STAT_TX_NAK | CTR_TX_BIT;
        r = r ^ DTOG_TX_BIT;
        return r;
    endfunction

endpackage

@@ rtl/usbep_bank.sv @@
// usbep_bank: endpoint register bank with read-modify-write update and
// priority encode of pending complete flags; depends on usbep_pkg
module usbep_bank
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          commit,
    input  usbep_pkg::item_t              item,
    output logic [usbep_pkg::REG_W-1:0]   read_data,
    output usbep_pkg::pend_t              pend
);

    logic [usbep_pkg::REG_W-1:0] bank_reg  [usbep_pkg::NUM_ENDPOINTS];
    logic [usbep_pkg::REG_W-1:0] bank_next [usbep_pkg::NUM_ENDPOINTS];
    logic [usbep_pkg::REG_W-1:0] cur;
    logic [usbep_pkg::REG_W-1:0] upd;
    logic                        in_range;
    logic                        found;

    // select addressed entry, out-of-range reads as zero
    always_comb
    begin
        cur      = '0;
        in_range = 1'b0;
        for (int i = 0; i < usbep_pkg::NUM_ENDPOINTS; i++)
        begin
            if ({{(usbep_pkg::CMP_W-usbep_pkg::IDX_W){1'b0}}, item.ep_num}
                == usbep_pkg::CMP_W'(i))
            begin
                cur      = bank_reg[i];
                in_range = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (item.opcode)
            usbep_pkg::OP_WRITE:   upd = usbep_pkg::bus_write(cur, item.write_data);
            usbep_pkg::OP_RX_DONE: upd = usbep_pkg::rx_done(cur, item.setup_flag);
            usbep_pkg::OP_TX_DONE: upd = usbep_pkg::tx_done(cur);
            default:               upd = cur;
        endcase
    end

    assign read_data = in_range ? upd : '0;

    always_comb
    begin
        for (int i = 0; i < usbep_pkg::NUM_ENDPOINTS; i++)
        begin
            if ({{(usbep_pkg::CMP_W-usbep_pkg::IDX_W){1'b0}}, item.ep_num}
                == usbep_pkg::CMP_W'(i))
                bank_next[i] = upd;
            else
                bank_next[i] = bank_reg[i];
        end
    end

    // lowest entry with a complete flag, on the post-update bank
    always_comb
    begin
        found = 1'b0;
        pend  = '0;
        for (int i = 0; i < usbep_pkg::NUM_ENDPOINTS; i++)
        begin
            if (!found && ((bank_next[i] & usbep_pkg::CTR_MASK) != '0))
            begin
                found                 = 1'b1;
                pend.ctr_pending      = 1'b1;
                pend.pending_endpoint = usbep_pkg::IDX_W'(i);
                pend.pending_dir      = |(bank_next[i] & usbep_pkg::CTR_RX_BIT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < usbep_pkg::NUM_ENDPOINTS; i++)
                bank_reg[i] <= '0;
        end
        else if (commit)
        begin
            for (int i = 0; i < usbep_pkg::NUM_ENDPOINTS; i++)
                bank_reg[i] <= bank_next[i];
        end
    end

endmodule

@@ rtl/usb_endpoint_register_bank_core.sv @@
// usb_endpoint_register_bank_core: top level with input register, bank
// update and result register; depends on usbep_pkg and usbep_bank
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  input   | in_valid, in_stall, opcode, ep_num,                  | in
//          | write_data, setup_flag                               |
//  result  | out_valid, out_stall, read_data, ctr_pending,        | out
//          | pending_endpoint, pending_dir                        |
//
// one transfer per cycle sustained while out_stall is low; each item passes from
// acceptance through the input register and then the result register
// the bank is written at the same edge that loads the result, so the next
// item in the input register always sees the updated bank
// reset clears the bank to zero and empties both registers
// a stalled result holds the input register, which then stalls the input
module usb_endpoint_register_bank_core
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [2:0]                    ep_num,
    input  logic [15:0]                   write_data,
    input  logic                          setup_flag,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   read_data,
    output logic                          ctr_pending,
    output logic [2:0]                    pending_endpoint,
    output logic                          pending_dir
);

    // input register
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    usbep_pkg::item_t            s1_item_reg;

    // result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [usbep_pkg::REG_W-1:0] rd_reg;
    usbep_pkg::pend_t            pend_reg;

    logic                        advance;
    logic                        commit;
    logic                        accept;
    logic [usbep_pkg::REG_W-1:0] bank_rd;
    usbep_pkg::pend_t            bank_pend;

    // the result register can take a new value when empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign commit   = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (commit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    usbep_bank u_bank
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .item      (s1_item_reg),
        .read_data (bank_rd),
        .pend      (bank_pend)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.opcode     <= usbep_pkg::op_t'(opcode);
            s1_item_reg.ep_num     <= ep_num;
            s1_item_reg.write_data <= write_data;
            s1_item_reg.setup_flag <= setup_flag;
        end
        if (commit)
        begin
            rd_reg   <= bank_rd;
            pend_reg <= bank_pend;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = rd_reg;
    assign ctr_pending      = pend_reg.ctr_pending;
    assign pending_endpoint = pend_reg.pending_endpoint;
    assign pending_dir      = pend_reg.pending_dir;

endmodule
